>>> rtl/core/mke_pkg.sv
// Shared types, constants and the Morse pattern tables of the keyer encoder.
package mke_pkg;

   localparam int CHAR_W      = 8;
   localparam int PAT_W       = 13;
   localparam int PAT_LEN_W   = 4;
   localparam int LGAP_W      = 3;
   localparam int WGAP_W      = 4;
   localparam int OFF_W       = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [LGAP_W-1:0] LETTER_GAP_RESET = 3'd3;
   localparam logic [WGAP_W-1:0] WORD_GAP_RESET   = 4'd4;

   localparam logic [CSR_IDX_W-1:0] REG_LETTER_GAP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_WORD_GAP   = 1'b1;

   localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5a;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7a;
   localparam logic [CHAR_W-1:0] ASCII_CASE    = 8'h20;

   // One classified character: what the back end has to send.
   typedef struct packed {
      logic [PAT_W-1:0]     pattern;
      logic [PAT_LEN_W-1:0] pat_len;
      logic [OFF_W-1:0]     off_len;
      logic                 unknown;
   } cmd_type;

   // Key pattern of a letter, first unit in bit 0.
   function automatic logic [PAT_W-1:0] morse_pattern(input logic [4:0] idx);
      logic [PAT_W-1:0] p;
      case (idx)
         5'd0:    p = 13'h001D;
         5'd1:    p = 13'h0157;
         5'd2:    p = 13'h05D7;
         5'd3:    p = 13'h0057;
         5'd4:    p = 13'h0001;
         5'd5:    p = 13'h0175;
         5'd6:    p = 13'h0177;
         5'd7:    p = 13'h0055;
         5'd8:    p = 13'h0005;
         5'd9:    p = 13'h1DDD;
         5'd10:   p = 13'h01D7;
         5'd11:   p = 13'h015D;
         5'd12:   p = 13'h0077;
         5'd13:   p = 13'h0017;
         5'd14:   p = 13'h0777;
         5'd15:   p = 13'h05DD;
         5'd16:   p = 13'h1D77;
         5'd17:   p = 13'h005D;
         5'd18:   p = 13'h0015;
         5'd19:   p = 13'h0007;
         5'd20:   p = 13'h0075;
         5'd21:   p = 13'h01D5;
         5'd22:   p = 13'h01DD;
         5'd23:   p = 13'h0757;
         5'd24:   p = 13'h1DD7;
         5'd25:   p = 13'h0577;
         default: p = '0;
      endcase
      return p;
   endfunction

   // Number of key units in a letter's pattern.
   function automatic logic [PAT_LEN_W-1:0] morse_length(input logic [4:0] idx);
      logic [PAT_LEN_W-1:0] n;
      case (idx)
         5'd0:    n = 4'd5;
         5'd1:    n = 4'd9;
         5'd2:    n = 4'd11;
         5'd3:    n = 4'd7;
         5'd4:    n = 4'd1;
         5'd5:    n = 4'd9;
         5'd6:    n = 4'd9;
         5'd7:    n = 4'd7;
         5'd8:    n = 4'd3;
         5'd9:    n = 4'd13;
         5'd10:   n = 4'd9;
         5'd11:   n = 4'd9;
         5'd12:   n = 4'd7;
         5'd13:   n = 4'd5;
         5'd14:   n = 4'd11;
         5'd15:   n = 4'd11;
         5'd16:   n = 4'd13;
         5'd17:   n = 4'd7;
         5'd18:   n = 4'd5;
         5'd19:   n = 4'd3;
         5'd20:   n = 4'd7;
         5'd21:   n = 4'd9;
         5'd22:   n = 4'd9;
         5'd23:   n = 4'd11;
         5'd24:   n = 4'd13;
         5'd25:   n = 4'd11;
         default: n = '0;
      endcase
      return n;
   endfunction

endpackage

>>> rtl/core/mke_front.sv
// Front end: gap registers, character acceptance and classification.
module mke_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [mke_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mke_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mke_pkg::CHAR_W-1:0]      req_tdata,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output mke_pkg::cmd_type                cmd
);
   import mke_pkg::*;

   logic [LGAP_W-1:0] letter_gap_ff, letter_gap_in;
   logic [WGAP_W-1:0] word_gap_ff, word_gap_in;
   logic [CHAR_W-1:0] upper;
   logic              is_lower, is_letter, is_space;
   logic [4:0]        idx;

   always_comb begin
      letter_gap_in = letter_gap_ff;
      word_gap_in   = word_gap_ff;
      if (csr_we) begin
         case (csr_index)
            REG_LETTER_GAP: letter_gap_in = csr_wdata[LGAP_W-1:0];
            REG_WORD_GAP:   word_gap_in   = csr_wdata[WGAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         letter_gap_ff <= LETTER_GAP_RESET;
         word_gap_ff   <= WORD_GAP_RESET;
      end else begin
         letter_gap_ff <= letter_gap_in;
         word_gap_ff   <= word_gap_in;
      end
   end

   // Fold lower case onto upper case, then sort into letter, space or other.
   always_comb begin
      is_lower  = (req_tdata >= ASCII_LOWER_A) && (req_tdata <= ASCII_LOWER_Z);
      upper     = is_lower ? (req_tdata - ASCII_CASE) : req_tdata;
      is_letter = (upper >= ASCII_UPPER_A) && (upper <= ASCII_UPPER_Z);
      is_space  = (req_tdata == ASCII_SPACE);
      idx       = 5'(upper - ASCII_UPPER_A);

      cmd.pattern = is_letter ? morse_pattern(idx) : '0;
      cmd.pat_len = is_letter ? morse_length(idx) : '0;
      cmd.off_len = OFF_W'(letter_gap_ff)
                    + (is_space ? OFF_W'(word_gap_ff) : OFF_W'(0));
      cmd.unknown = !is_letter && !is_space;
   end

   assign cmd_valid  = req_tvalid;
   assign req_tready = cmd_ready;

endmodule

>>> rtl/core/mke_queue.sv
// Short queue of classified characters between the front and back ends.
module mke_queue #(
   parameter int DEPTH = mke_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  mke_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output mke_pkg::cmd_type out_cmd
);
   import mke_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push, pop;

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

>>> rtl/core/mke_back.sv
// Back end: unit sequencer that plays one character into the result register.
module mke_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  mke_pkg::cmd_type cmd,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic             rsp_key,
   output logic             rsp_unknown,
   output logic             rsp_last
);
   import mke_pkg::*;

   logic                 busy_ff, busy_in;
   logic [PAT_W-1:0]     bits_ff, bits_in;
   logic [PAT_LEN_W-1:0] pat_cnt_ff, pat_cnt_in;
   logic [OFF_W-1:0]     off_cnt_ff, off_cnt_in;
   logic                 unk_ff, unk_in;
   logic                 valid_ff, valid_in;
   logic                 key_ff, key_in;
   logic                 out_unk_ff, out_unk_in;
   logic                 last_ff, last_in;
   logic                 advance, step_last;

   assign cmd_ready = !busy_ff;
   assign advance   = !valid_ff || rsp_tready;
   assign step_last = ((pat_cnt_ff == PAT_LEN_W'(1)) && (off_cnt_ff == '0))
                   || ((pat_cnt_ff == '0) && (off_cnt_ff == OFF_W'(1)));

   always_comb begin
      busy_in    = busy_ff;
      bits_in    = bits_ff;
      pat_cnt_in = pat_cnt_ff;
      off_cnt_in = off_cnt_ff;
      unk_in     = unk_ff;
      valid_in   = valid_ff && !rsp_tready;
      key_in     = key_ff;
      out_unk_in = out_unk_ff;
      last_in    = last_ff;

      if (!busy_ff) begin
         if (cmd_valid) begin
            // A character with no units at all is dropped here.
            busy_in    = (cmd.pat_len != '0) || (cmd.off_len != '0);
            bits_in    = cmd.pattern;
            pat_cnt_in = cmd.pat_len;
            off_cnt_in = cmd.off_len;
            unk_in     = cmd.unknown;
         end
      end else if (advance) begin
         valid_in   = 1'b1;
         out_unk_in = unk_ff;
         last_in    = step_last;
         busy_in    = !step_last;
         if (pat_cnt_ff != '0) begin
            key_in     = bits_ff[0];
            bits_in    = bits_ff >> 1;
            pat_cnt_in = pat_cnt_ff - 1'b1;
         end else begin
            key_in     = 1'b0;
            off_cnt_in = off_cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff    <= bits_in;
      pat_cnt_ff <= pat_cnt_in;
      off_cnt_ff <= off_cnt_in;
      unk_ff     <= unk_in;
      key_ff     <= key_in;
      out_unk_ff <= out_unk_in;
      last_ff    <= last_in;
   end

   assign rsp_tvalid  = valid_ff;
   assign rsp_key     = key_ff;
   assign rsp_unknown = out_unk_ff;
   assign rsp_last    = last_ff;

endmodule

>>> rtl/core/morse_keyer_encoder.sv
// Top level of the Morse keyer encoder: character stream in, key units out.
//
//  Channel  Direction  Transaction carries
//  req_     in         tdata[7:0] char_code
//  rsp_     out        tdata[0] key_on (rest zero), tuser unknown_char, tlast last
//  csr_     in         csr_index selects letter gap (0) or word gap (1)
//
//  The back end loads one character at a time and then plays its key units
//  (0 to 22 units); the back-end unit sequencer plays one unit per cycle
//  while rsp_ is not stalled, and takes no new character until it is done.
//  A character that yields no results is dropped when the back end loads it.
//  Reset is synchronous and active high; it empties the queue, idles the
//  sequencer and restores the gaps to 3 and 4 units.
//  A stall on rsp_ holds the result register; the queue keeps taking
//  characters until it is full.
module morse_keyer_encoder #(
   parameter int QUEUE_DEPTH = mke_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration write port.
   input  logic                            csr_we,
   input  logic [mke_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mke_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // Character input.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] char_code
   // Key unit output.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,  // [0] key_on, [7:1] zero
   output logic                            rsp_tuser,  // [0] unknown_char
   output logic                            rsp_tlast
);
   import mke_pkg::*;

   cmd_type front_cmd, back_cmd;
   logic    front_valid, front_ready;
   logic    back_valid, back_ready;
   logic    key;

   // The front end classifies each character as it is accepted; the result
   // of classification is a complete plan for the back end.
   mke_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   // The queue lets new characters in while the back end is still keying.
   mke_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_cmd   (back_cmd)
   );

   // The back end expands one plan at a time into key units.
   mke_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (back_valid),
      .cmd_ready   (back_ready),
      .cmd         (back_cmd),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_key     (key),
      .rsp_unknown (rsp_tuser),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {7'b0, key};

endmodule

>>> rtl/core/mke_checker.sv
// Port-level checker for the Morse keyer encoder, bound to the top level.
module mke_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // No result is offered in the cycle after a reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // An unknown character only ever produces key-off units.
   a_unknown_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tuser))
      else $error("key on during an unknown character");

   // Padding bits of the result data stay zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:1] == 7'd0))
      else $error("nonzero padding in result data");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind morse_keyer_encoder mke_checker u_mke_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
